// File: design/fragment_depth_fog_blend_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for fragment_depth_fog_blend
// Short forms for concurrent checks clocked by aclk, with reset masking.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_DEPTH_FOG_BLEND_ASSERT_SVH
`define FRAGMENT_DEPTH_FOG_BLEND_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDFB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fdfb_pkg.sv
// ----------------------------------------------------------------------------
// fdfb_pkg
// Shared types and constants of the fragment depth, fog and blend block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdfb_pkg;

    // Far plane depth in signed Q2.16 (1.0).
    localparam logic signed [17:0] DEPTH_FAR = 18'sh10000;

    // Shared divider sizes: divisor, dividend shift line, step counter.
    localparam int DVS_W = 51;
    localparam int DVD_W = 81;
    localparam int CNT_W = 7;
    localparam int QUO_W = 33;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BLEND_ENABLE  = 3'd0,
        CFG_CONTRAST_GAIN = 3'd1,
        CFG_FOG_MODE      = 3'd2,
        CFG_FOG_START     = 3'd3,
        CFG_FOG_END       = 3'd4,
        CFG_FOG_RGBA      = 3'd5,
        CFG_NEAR_PLANE    = 3'd6,
        CFG_FAR_PLANE     = 3'd7
    } cfg_idx_t;

    // Fog mode codes.
    localparam logic [1:0] FOG_OFF   = 2'd0;
    localparam logic [1:0] FOG_NDC   = 2'd1;
    localparam logic [1:0] FOG_PERSP = 2'd2;
    localparam logic [1:0] FOG_ORTHO = 2'd3;

    // Command from the sequencer to the divider.
    typedef struct packed {
        logic             start;
        logic [DVS_W-1:0] rem_init;
        logic [DVS_W-1:0] divisor;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] steps;
    } fdfb_div_cmd_t;

    // Status returned by the divider.
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quot;
    } fdfb_div_sts_t;

endpackage

`default_nettype wire

// File: design/fdfb_ram.sv
// ----------------------------------------------------------------------------
// fdfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/fdfb_div.sv
// ----------------------------------------------------------------------------
// fdfb_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdfb_div (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire fdfb_pkg::fdfb_div_cmd_t cmd,
    output fdfb_pkg::fdfb_div_sts_t      sts
);

    import fdfb_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [QUO_W-1:0] quot_reg;
    logic             ovf_reg;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg  <= cmd.rem_init;
            dvs_reg  <= cmd.divisor;
            dvd_reg  <= cmd.dividend;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUO_W-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[QUO_W-1];
        end
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign sts.quot = quot_reg;

endmodule

`default_nettype wire

// File: design/fragment_depth_fog_blend.sv
// The time from an accepted transaction to its result depends on the path: a failed depth
// test is the shortest, then fog off, NDC fog, orthographic fog and perspective fog.
// A new transaction is accepted only once the result is posted, and posting waits for the
// previous result to drain from the result channel.
// The shared restoring divider runs 8 steps per fog channel and 81 for a perspective division.
// After reset both stores are cleared before the first transaction is accepted.
// ----------------------------------------------------------------------------
// fragment_depth_fog_blend
// Raster output stage: depth test, contrast, fog and alpha blend per fragment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fragment_depth_fog_blend_assert.svh"

module fragment_depth_fog_blend #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration write port.
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    // Fragment input channel.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_pixel_x,
    input  wire logic [7:0]         s_pixel_y,
    input  wire logic signed [17:0] s_frag_depth,
    input  wire logic [7:0]         s_red,
    input  wire logic [7:0]         s_green,
    input  wire logic [7:0]         s_blue,
    input  wire logic [7:0]         s_alpha,
    // Result channel.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_written,
    output logic [7:0]              m_out_red,
    output logic [7:0]              m_out_green,
    output logic [7:0]              m_out_blue,
    output logic [7:0]              m_out_alpha
);

    import fdfb_pkg::*;

    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Sequencer states, one-hot.
    typedef enum logic [15:0] {
        ST_CLEAR    = 16'h0001,
        ST_IDLE     = 16'h0002,
        ST_READ     = 16'h0004,
        ST_TEST     = 16'h0008,
        ST_CONTRAST = 16'h0010,
        ST_WMUL     = 16'h0020,
        ST_WDIST    = 16'h0040,
        ST_WDIV     = 16'h0080,
        ST_WWAIT    = 16'h0100,
        ST_FOGT     = 16'h0200,
        ST_MIXA     = 16'h0400,
        ST_MIXB     = 16'h0800,
        ST_MIXC     = 16'h1000,
        ST_MIXD     = 16'h2000,
        ST_BLEND    = 16'h4000,
        ST_WRITE    = 16'h8000
    } state_t;

    // Contrast around mid grey, Q4.8 gain, clamped to 0..255.
    function automatic logic [7:0] contrast_ch(input logic [7:0] c, input logic [11:0] gain);
        logic signed [10:0] d;
        logic signed [24:0] num;
        d   = $signed({2'b00, c, 1'b0}) - 11'sd255;
        num = d * $signed({1'b0, gain}) + 25'sd65280;
        if (num[24]) begin
            return 8'd0;
        end else if (num[23:9] > 15'd255) begin
            return 8'd255;
        end else begin
            return num[16:9];
        end
    endfunction

    // Floor division by 255, exact for the blend sums (at most 255*255).
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [16:0] s;
        s = x + (x >> 8) + 17'd1;
        return s[15:8];
    endfunction

    // Configuration registers.
    logic               blend_reg;
    logic [11:0]        gain_reg;
    logic [1:0]         fog_mode_reg;
    logic signed [31:0] fog_start_reg;
    logic signed [31:0] fog_end_reg;
    logic [31:0]        fog_rgba_reg;
    logic [31:0]        near_reg;
    logic [31:0]        far_reg;

    // Sequencer and fragment registers.
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               in_frame_reg;
    logic               pass_reg;
    logic signed [17:0] z_reg;
    logic [7:0]         ch_reg [4];
    logic [1:0]         k_reg;

    // Fog datapath registers.
    logic signed [50:0] prod_zd_reg;
    logic [63:0]        nf_reg;
    logic signed [51:0] den_reg;
    logic signed [31:0] fd_reg;
    logic [32:0]        span_reg;
    logic [32:0]        t_reg;
    logic [40:0]        p1_reg;
    logic [40:0]        mix_n_reg;

    // Result register.
    logic               m_valid_reg;
    logic               m_written_reg;
    logic [7:0]         m_ch_reg [4];

    // Memory ports.
    logic               depth_we, colour_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [17:0]        depth_wdata, depth_rdata;
    logic [31:0]        colour_wdata, colour_rdata;

    fdfb_div_cmd_t      div_cmd;
    fdfb_div_sts_t      div_sts;

    // Handshake helpers.
    logic               s_fire;
    logic               out_free;

    // Combinational datapath values.
    logic [32:0]        sum_fn;
    logic [31:0]        diff_fn;
    logic               degen;
    logic signed [51:0] sum_sh;
    logic signed [51:0] prod_ext;
    logic signed [51:0] ortho_v;
    logic signed [34:0] ortho_fl;
    logic signed [31:0] ortho_sat;
    logic [31:0]        far_sat;
    logic signed [31:0] persp_q;
    logic signed [32:0] span_s;
    logic signed [33:0] t_raw;
    logic signed [33:0] t_adj;
    logic [32:0]        span_mag;
    logic [32:0]        t_clamp;
    logic [7:0]         fog_ch;
    logic [7:0]         blend_ch [4];
    logic [7:0]         inv_a;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Configuration writes. Writes are to be made only while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_reg     <= 1'b0;
            gain_reg      <= 12'd256;
            fog_mode_reg  <= FOG_OFF;
            fog_start_reg <= 32'sd0;
            fog_end_reg   <= 32'sd65536;
            fog_rgba_reg  <= 32'd0;
            near_reg      <= 32'd6554;
            far_reg       <= 32'd6553600;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLEND_ENABLE:  blend_reg     <= cfg_wdata[0];
                CFG_CONTRAST_GAIN: gain_reg      <= cfg_wdata[11:0];
                CFG_FOG_MODE:      fog_mode_reg  <= cfg_wdata[1:0];
                CFG_FOG_START:     fog_start_reg <= $signed(cfg_wdata);
                CFG_FOG_END:       fog_end_reg   <= $signed(cfg_wdata);
                CFG_FOG_RGBA:      fog_rgba_reg  <= cfg_wdata;
                CFG_NEAR_PLANE:    near_reg      <= cfg_wdata;
                CFG_FAR_PLANE:     far_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // World distance arithmetic. The projection is inverted from the
    // registered products: orthographic is a shift of a sum, perspective
    // needs the divider.
    // ------------------------------------------------------------------
    always_comb begin
        sum_fn   = 33'(far_reg) + 33'(near_reg);
        diff_fn  = far_reg - near_reg;
        degen    = !(far_reg > near_reg) || (near_reg == 32'd0);
        sum_sh   = $signed({3'b000, sum_fn, 16'h0000});
        prod_ext = {prod_zd_reg[50], prod_zd_reg};
        ortho_v  = sum_sh + prod_ext;
        ortho_fl = 35'(ortho_v >>> 17);
        if (ortho_fl > 35'sh0_7FFF_FFFF) begin
            ortho_sat = 32'sh7FFF_FFFF;
        end else if (ortho_fl < -35'sh0_8000_0000) begin
            ortho_sat = 32'sh8000_0000;
        end else begin
            ortho_sat = ortho_fl[31:0];
        end
        far_sat = far_reg[31] ? 32'h7FFF_FFFF : far_reg;

        // Saturate the perspective quotient according to the sign of den.
        if (!den_reg[51]) begin
            if (div_sts.ovf || div_sts.quot[32] || div_sts.quot[31]) begin
                persp_q = 32'sh7FFF_FFFF;
            end else begin
                persp_q = $signed(div_sts.quot[31:0]);
            end
        end else begin
            if (div_sts.ovf || (div_sts.quot > 33'h0_8000_0000)) begin
                persp_q = 32'sh8000_0000;
            end else begin
                persp_q = $signed(32'd0 - div_sts.quot[31:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Fog span and distance. An empty span is full fog at or past the
    // start; a negative span is mirrored, distance included.
    // ------------------------------------------------------------------
    always_comb begin
        span_s = 33'(fog_end_reg) - 33'(fog_start_reg);
        t_raw  = 34'(fd_reg) - 34'(fog_start_reg);
        if (span_s == 33'sd0) begin
            span_mag = 33'd1;
            t_adj    = (fd_reg >= fog_start_reg) ? 34'sd1 : 34'sd0;
        end else if (span_s[32]) begin
            span_mag = 33'd0 - span_s;
            t_adj    = 34'sd0 - t_raw;
        end else begin
            span_mag = span_s;
            t_adj    = t_raw;
        end
        if (t_adj[33]) begin
            t_clamp = 33'd0;
        end else if (t_adj > $signed({1'b0, span_mag})) begin
            t_clamp = span_mag;
        end else begin
            t_clamp = t_adj[32:0];
        end
        fog_ch = fog_rgba_reg[8*(3-k_reg) +: 8];
    end

    // ------------------------------------------------------------------
    // Alpha blend over the stored colour, all four channels at once.
    // ------------------------------------------------------------------
    always_comb begin
        inv_a = 8'd255 - ch_reg[3];
        for (int i = 0; i < 3; i++) begin
            blend_ch[i] = div255(17'(ch_reg[i]) * 17'(ch_reg[3])
                               + 17'(colour_rdata[8*(3-i) +: 8]) * 17'(inv_a));
        end
        blend_ch[3] = ch_reg[3] + div255(17'(colour_rdata[7:0]) * 17'(inv_a));
    end

    // ------------------------------------------------------------------
    // Divider commands: one perspective division or one fog channel mix.
    // For a mix the quotient is below 256, so the upper numerator bits
    // seed the remainder and only eight steps remain.
    // ------------------------------------------------------------------
    always_comb begin
        div_cmd = '0;
        if (state_reg == ST_WDIV) begin
            div_cmd.start    = (den_reg != 52'sd0);
            div_cmd.rem_init = '0;
            div_cmd.divisor  = den_reg[51] ? DVS_W'(52'sd0 - den_reg) : DVS_W'(den_reg);
            div_cmd.dividend = {nf_reg, 17'h0};
            div_cmd.steps    = CNT_W'(DVD_W);
        end else if (state_reg == ST_MIXC) begin
            div_cmd.start    = 1'b1;
            div_cmd.rem_init = DVS_W'(mix_n_reg[40:8]);
            div_cmd.divisor  = DVS_W'(span_reg);
            div_cmd.dividend = {mix_n_reg[7:0], (DVD_W-8)'(0)};
            div_cmd.steps    = CNT_W'(8);
        end
    end

    fdfb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .sts     (div_sts)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_TEST;
            ST_TEST: begin
                if (in_frame_reg && (z_reg < $signed(depth_rdata))) begin
                    state_next = ST_CONTRAST;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_CONTRAST: begin
                if (fog_mode_reg == FOG_OFF) begin
                    state_next = ST_BLEND;
                end else if (fog_mode_reg == FOG_NDC) begin
                    state_next = ST_FOGT;
                end else begin
                    state_next = ST_WMUL;
                end
            end
            ST_WMUL: state_next = ST_WDIST;
            ST_WDIST: begin
                if (degen || (fog_mode_reg == FOG_ORTHO)) begin
                    state_next = ST_FOGT;
                end else begin
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV: begin
                state_next = (den_reg == 52'sd0) ? ST_FOGT : ST_WWAIT;
            end
            ST_WWAIT: begin
                if (div_sts.done) begin
                    state_next = ST_FOGT;
                end
            end
            ST_FOGT: state_next = ST_MIXA;
            ST_MIXA: state_next = ST_MIXB;
            ST_MIXB: state_next = ST_MIXC;
            ST_MIXC: state_next = ST_MIXD;
            ST_MIXD: begin
                if (div_sts.done) begin
                    state_next = (k_reg == 2'd3) ? ST_BLEND : ST_MIXA;
                end
            end
            ST_BLEND: state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if ((state_reg == ST_WRITE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Fragment and datapath registers (no reset needed).
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            idx_reg      <= ADDR_W'(32'(s_pixel_y) * 32'(FRAME_WIDTH) + 32'(s_pixel_x));
            in_frame_reg <= (32'(s_pixel_x) < 32'(FRAME_WIDTH))
                         && (32'(s_pixel_y) < 32'(FRAME_HEIGHT));
            z_reg        <= s_frag_depth;
            ch_reg[0]    <= s_red;
            ch_reg[1]    <= s_green;
            ch_reg[2]    <= s_blue;
            ch_reg[3]    <= s_alpha;
        end
        if (state_reg == ST_TEST) begin
            pass_reg <= in_frame_reg && (z_reg < $signed(depth_rdata));
        end
        if (state_reg == ST_CONTRAST) begin
            for (int i = 0; i < 3; i++) begin
                ch_reg[i] <= contrast_ch(ch_reg[i], gain_reg);
            end
            fd_reg <= 32'(z_reg);
            k_reg  <= 2'd0;
        end
        if (state_reg == ST_WMUL) begin
            prod_zd_reg <= z_reg * $signed({1'b0, diff_fn});
            nf_reg      <= 64'(near_reg) * 64'(far_reg);
        end
        if (state_reg == ST_WDIST) begin
            den_reg <= sum_sh - prod_ext;
            if (degen) begin
                fd_reg <= 32'sd0;
            end else if (fog_mode_reg == FOG_ORTHO) begin
                fd_reg <= ortho_sat;
            end
        end
        if ((state_reg == ST_WDIV) && (den_reg == 52'sd0)) begin
            fd_reg <= $signed(far_sat);
        end
        if ((state_reg == ST_WWAIT) && div_sts.done) begin
            fd_reg <= persp_q;
        end
        if (state_reg == ST_FOGT) begin
            span_reg <= span_mag;
            t_reg    <= t_clamp;
        end
        if (state_reg == ST_MIXA) begin
            p1_reg <= ch_reg[k_reg] * (span_reg - t_reg);
        end
        if (state_reg == ST_MIXB) begin
            mix_n_reg <= p1_reg + fog_ch * t_reg;
        end
        if ((state_reg == ST_MIXD) && div_sts.done) begin
            ch_reg[k_reg] <= div_sts.quot[7:0];
            k_reg         <= k_reg + 2'd1;
        end
        if ((state_reg == ST_BLEND) && blend_reg) begin
            for (int i = 0; i < 4; i++) begin
                ch_reg[i] <= blend_ch[i];
            end
        end
        if ((state_reg == ST_WRITE) && out_free) begin
            m_written_reg <= pass_reg;
            for (int i = 0; i < 4; i++) begin
                m_ch_reg[i] <= pass_reg ? ch_reg[i] : 8'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Depth and colour stores. The clearing pass writes the far plane
    // depth and black into every pixel; a passing fragment writes its
    // colour, and its depth too unless blending is on.
    // ------------------------------------------------------------------
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_waddr    = clr_reg;
            depth_we     = 1'b1;
            colour_we    = 1'b1;
            depth_wdata  = DEPTH_FAR;
            colour_wdata = 32'd0;
        end else begin
            mem_waddr    = idx_reg;
            colour_we    = (state_reg == ST_WRITE) && out_free && pass_reg;
            depth_we     = colour_we && !blend_reg;
            depth_wdata  = z_reg;
            colour_wdata = {ch_reg[0], ch_reg[1], ch_reg[2], ch_reg[3]};
        end
    end

    fdfb_ram #(
        .DATA_W (18),
        .DEPTH  (STORE_DEPTH)
    ) u_depth_ram (
        .aclk  (aclk),
        .we    (depth_we),
        .waddr (mem_waddr),
        .wdata (depth_wdata),
        .raddr (idx_reg),
        .rdata (depth_rdata)
    );

    fdfb_ram #(
        .DATA_W (32),
        .DEPTH  (STORE_DEPTH)
    ) u_colour_ram (
        .aclk  (aclk),
        .we    (colour_we),
        .waddr (mem_waddr),
        .wdata (colour_wdata),
        .raddr (idx_reg),
        .rdata (colour_rdata)
    );

    // Result channel outputs.
    assign m_valid     = m_valid_reg;
    assign m_written   = m_written_reg;
    assign m_out_red   = m_ch_reg[0];
    assign m_out_green = m_ch_reg[1];
    assign m_out_blue  = m_ch_reg[2];
    assign m_out_alpha = m_ch_reg[3];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `FDFB_ASSERT_SAME(a_div_done_state, div_sts.done,
        (state_reg == ST_WWAIT) || (state_reg == ST_MIXD),
        "divider finished outside a waiting state")
    `FDFB_ASSERT_SAME(a_store_write_state, depth_we || colour_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_WRITE),
        "store written outside clear or write")
    `FDFB_ASSERT_NEXT(a_accept_reads, s_fire, state_reg == ST_READ,
        "accepted transaction did not start a store read")

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fragment depth test, fog and blend stage. A
// scoreboard model of the depth and colour stores predicts every result
// transaction, and random idling on both channels exercises the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fdfb_pkg::*;

    localparam int  FRAME_PIXELS = 256 * 256;
    localparam int  DRAIN_CYCLES = 300;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    // One fragment as presented on the input channel.
    typedef struct {
        logic [7:0]         x;
        logic [7:0]         y;
        logic signed [17:0] z;
        logic [7:0]         rgba [4];
    } fragment_t;

    // One pixel result as seen on the output channel.
    typedef struct {
        logic       written;
        logic [7:0] rgba [4];
    } pixel_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_pixel_x = '0;
    logic [7:0]         s_pixel_y = '0;
    logic signed [17:0] s_frag_depth = '0;
    logic [7:0]         s_red = '0;
    logic [7:0]         s_green = '0;
    logic [7:0]         s_blue = '0;
    logic [7:0]         s_alpha = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_written;
    logic [7:0]         m_out_red;
    logic [7:0]         m_out_green;
    logic [7:0]         m_out_blue;
    logic [7:0]         m_out_alpha;

    fragment_depth_fog_blend dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .s_frag_depth (s_frag_depth),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_written    (m_written),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the configuration registers, updated on every write.
    logic         sh_blend;
    logic [11:0]  sh_gain;
    logic [1:0]   sh_fog_mode;
    longint       sh_fog_start;
    longint       sh_fog_end;
    logic [31:0]  sh_fog_rgba;
    longint       sh_near;
    longint       sh_far;

    // Shadow copy of the frame stores.
    logic signed [17:0] depth_buf [FRAME_PIXELS];
    logic [31:0]        colour_buf [FRAME_PIXELS];

    fragment_t     frag_q [$];
    pixel_result_t pixel_expect_q [$];
    fragment_t     cur_frag;
    int            idle_mode = 0;
    int            errors = 0;

    // Contrast around mid grey in Q4.8, clamped to the byte range.
    function automatic logic [7:0] contrast_byte(logic [7:0] c);
        longint num;
        num = (2 * longint'(c) - 255) * longint'(sh_gain) + 65280;
        if (num < 0) return 8'd0;
        num = num / 512;
        return num > 255 ? 8'd255 : num[7:0];
    endfunction

    function automatic longint clamp32(longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < SAT_MIN) return SAT_MIN;
        return v;
    endfunction

    // Eye-space distance recovered from NDC depth, signed Q16.16.
    function automatic longint world_dist(longint z, bit ortho);
        longint sum, diff, den, num;
        longint unsigned dm, nf, rem, q, dbit;
        bit big;
        if (!(sh_far > sh_near) || sh_near == 0) return 0;
        sum  = sh_far + sh_near;
        diff = sh_far - sh_near;
        if (ortho) begin
            num = z * diff + sum * 65536;
            // Floor division by 2^17; division in SV truncates toward zero.
            if (num < 0 && (num % 131072) != 0) return clamp32(num / 131072 - 1);
            return clamp32(num / 131072);
        end
        den = sum * 65536 - z * diff;
        if (den == 0) return clamp32(sh_far);
        dm = den < 0 ? longint'(-den) : longint'(den);
        nf = longint'(sh_near) * longint'(sh_far);
        rem = 0;
        q = 0;
        big = 1'b0;
        // Long division of nf * 2^17 by the denominator, with early saturation.
        for (int i = 80; i >= 0; i--) begin
            dbit = i >= 17 ? (nf >> (i - 17)) & 64'd1 : 64'd0;
            rem = (rem << 1) | dbit;
            if (q > (64'd1 << 40)) big = 1'b1;
            else q = q << 1;
            if (rem >= dm) begin
                rem = rem - dm;
                if (!big) q = q | 64'd1;
            end
        end
        if (den > 0) return (big || q > 64'd2147483647) ? SAT_MAX : longint'(q);
        return (big || q > (64'd1 << 31)) ? SAT_MIN : -longint'(q);
    endfunction

    // Full per-fragment prediction; updates the shadow stores as the block does.
    function automatic pixel_result_t predict_pixel(fragment_t f);
        pixel_result_t res;
        int     idx;
        logic [7:0] ch [4];
        logic [31:0] dst;
        longint fd, span, t, a, ia, d;
        res.written = 1'b0;
        for (int k = 0; k < 4; k++) res.rgba[k] = 8'd0;
        idx = int'(f.y) * 256 + int'(f.x);
        // Strictly nearer than the stored depth, or it is dropped.
        if (!(f.z < depth_buf[idx])) return res;
        for (int k = 0; k < 4; k++) ch[k] = f.rgba[k];
        for (int k = 0; k < 3; k++) ch[k] = contrast_byte(ch[k]);
        if (sh_fog_mode != FOG_OFF) begin
            fd = sh_fog_mode == FOG_NDC ? longint'(f.z)
                                        : world_dist(longint'(f.z), sh_fog_mode == FOG_ORTHO);
            span = sh_fog_end - sh_fog_start;
            t = fd - sh_fog_start;
            if (span == 0) begin
                // An empty span is a hard step at the start distance.
                span = 1;
                t = fd >= sh_fog_start ? 1 : 0;
            end else if (span < 0) begin
                span = -span;
                t = -t;
            end
            if (t < 0) t = 0;
            if (t > span) t = span;
            for (int k = 0; k < 4; k++)
                ch[k] = 8'((longint'(ch[k]) * (span - t)
                           + longint'(sh_fog_rgba[31 - 8 * k -: 8]) * t) / span);
        end
        if (sh_blend) begin
            dst = colour_buf[idx];
            a  = ch[3];
            ia = 255 - a;
            for (int k = 0; k < 3; k++) begin
                d = dst[31 - 8 * k -: 8];
                ch[k] = 8'((longint'(ch[k]) * a + d * ia) / 255);
            end
            ch[3] = 8'(a + (longint'(dst[7:0]) * ia) / 255);
        end else begin
            depth_buf[idx] = f.z;
        end
        colour_buf[idx] = {ch[0], ch[1], ch[2], ch[3]};
        res.written = 1'b1;
        for (int k = 0; k < 4; k++) res.rgba[k] = ch[k];
        return res;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_pause();
        return (idle_mode == 1 && roll(67)) || (idle_mode == 3 && roll(10));
    endfunction

    function automatic bit receiver_stall();
        return (idle_mode == 2 && roll(67)) || (idle_mode == 3 && roll(10));
    endfunction

    // Driver: presents queued fragments and records a prediction per transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) pixel_expect_q.push_back(predict_pixel(cur_frag));
            if (!s_valid || s_ready) begin
                if (frag_q.size() > 0 && !sender_pause()) begin
                    cur_frag = frag_q.pop_front();
                    s_pixel_x    <= cur_frag.x;
                    s_pixel_y    <= cur_frag.y;
                    s_frag_depth <= cur_frag.z;
                    s_red        <= cur_frag.rgba[0];
                    s_green      <= cur_frag.rgba[1];
                    s_blue       <= cur_frag.rgba[2];
                    s_alpha      <= cur_frag.rgba[3];
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // Monitor: every result transaction is matched against the oldest prediction.
    always @(posedge aclk) begin
        pixel_result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_stall();
            if (m_valid && m_ready) begin
                if (pixel_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual written=%0d",
                             $time, m_written);
                end else begin
                    exp_r = pixel_expect_q.pop_front();
                    check_field("written", exp_r.written, m_written);
                    check_field("out_red", exp_r.rgba[0], m_out_red);
                    check_field("out_green", exp_r.rgba[1], m_out_green);
                    check_field("out_blue", exp_r.rgba[2], m_out_blue);
                    check_field("out_alpha", exp_r.rgba[3], m_out_alpha);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BLEND_ENABLE:  sh_blend     = val[0];
            CFG_CONTRAST_GAIN: sh_gain      = val[11:0];
            CFG_FOG_MODE:      sh_fog_mode  = val[1:0];
            CFG_FOG_START:     sh_fog_start = longint'(signed'(val));
            CFG_FOG_END:       sh_fog_end   = longint'(signed'(val));
            CFG_FOG_RGBA:      sh_fog_rgba  = val;
            CFG_NEAR_PLANE:    sh_near      = longint'(val);
            CFG_FAR_PLANE:     sh_far       = longint'(val);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Blocks until every queued fragment has produced its result, then lets the
    // block settle so that a following register write sees it idle.
    task automatic drain();
        while (frag_q.size() > 0 || s_valid || pixel_expect_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void queue_frag(int x, int y, int z, int r, int g, int b, int a);
        fragment_t f;
        f.x = x[7:0];
        f.y = y[7:0];
        f.z = z[17:0];
        f.rgba[0] = r[7:0];
        f.rgba[1] = g[7:0];
        f.rgba[2] = b[7:0];
        f.rgba[3] = a[7:0];
        frag_q.push_back(f);
    endfunction

    function automatic int rand_byte();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // Most fragments land in a small tile so that pixels are hit repeatedly,
    // which drives both passing and failing depth tests and blending.
    function automatic void queue_random_frag();
        int x, y, z;
        if (roll(75)) begin
            x = $urandom_range(15);
            y = $urandom_range(15);
        end else begin
            x = $urandom_range(255);
            y = $urandom_range(255);
        end
        if (roll(5)) z = int'($urandom_range(262143)) - 131072;
        else z = int'($urandom_range(131072)) - 65536;
        queue_frag(x, y, z, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endfunction

    function automatic logic [31:0] pick_dist(int sel);
        case (sel % 6)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic program_phase(int p);
        logic [31:0] fs;
        write_reg(CFG_BLEND_ENABLE, (p % 3 == 1) ? 32'd1 : 32'd0);
        case (p % 4)
            0: write_reg(CFG_CONTRAST_GAIN, 32'd256);
            1: write_reg(CFG_CONTRAST_GAIN, 32'd0);
            2: write_reg(CFG_CONTRAST_GAIN, 32'd4095);
            default: write_reg(CFG_CONTRAST_GAIN, $urandom_range(4095));
        endcase
        write_reg(CFG_FOG_MODE, 32'((p + p / 4) % 4));
        fs = pick_dist(p);
        write_reg(CFG_FOG_START, fs);
        // Every fifth phase uses an empty span; others random or extreme.
        write_reg(CFG_FOG_END, (p % 5 == 2) ? fs : pick_dist(p + 3 + $urandom_range(2)));
        write_reg(CFG_FOG_RGBA, (p % 7 == 0) ? 32'hFFFF_FFFF : $urandom);
        case (p % 6)
            0: begin
                write_reg(CFG_NEAR_PLANE, 32'd6554);
                write_reg(CFG_FAR_PLANE, 32'd6553600);
            end
            1: begin
                // Zero near plane is a degenerate projection.
                write_reg(CFG_NEAR_PLANE, 32'd0);
                write_reg(CFG_FAR_PLANE, $urandom);
            end
            2: begin
                // Far not beyond near is degenerate too.
                write_reg(CFG_NEAR_PLANE, 32'h0005_0000);
                write_reg(CFG_FAR_PLANE, 32'h0005_0000);
            end
            3: begin
                write_reg(CFG_NEAR_PLANE, 32'hFFFF_FFFE);
                write_reg(CFG_FAR_PLANE, 32'hFFFF_FFFF);
            end
            4: begin
                write_reg(CFG_NEAR_PLANE, 32'd1);
                write_reg(CFG_FAR_PLANE, 32'd5);
            end
            default: begin
                write_reg(CFG_NEAR_PLANE, $urandom_range(32'h0010_0000, 1));
                write_reg(CFG_FAR_PLANE, $urandom);
            end
        endcase
    endtask

    initial begin
        // Power-on state of the block's registers and stores.
        sh_blend     = 1'b0;
        sh_gain      = 12'd256;
        sh_fog_mode  = FOG_OFF;
        sh_fog_start = 0;
        sh_fog_end   = 65536;
        sh_fog_rgba  = 32'd0;
        sh_near      = 6554;
        sh_far       = 6553600;
        for (int i = 0; i < FRAME_PIXELS; i++) begin
            depth_buf[i]  = DEPTH_FAR;
            colour_buf[i] = 32'd0;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: frame corners, depth extremes, colour extremes, a repeated
        // pixel that fails the depth test, and an equal-depth tie.
        queue_frag(0, 0, -65536, 0, 0, 0, 0);
        queue_frag(255, 255, 65535, 255, 255, 255, 255);
        queue_frag(255, 0, 65536, 128, 127, 1, 254);
        queue_frag(0, 255, -131072, 255, 0, 255, 0);
        queue_frag(1, 1, 131071, 10, 20, 30, 40);
        queue_frag(0, 0, -65536, 9, 9, 9, 9);
        queue_frag(0, 0, -65537, 200, 100, 50, 25);
        queue_frag(3, 3, 0, 170, 85, 60, 128);
        queue_frag(3, 3, 1, 1, 2, 3, 4);
        drain();

        // Blend with fog on NDC depth over what was stored above.
        write_reg(CFG_BLEND_ENABLE, 32'd1);
        write_reg(CFG_FOG_MODE, 32'(FOG_NDC));
        write_reg(CFG_FOG_RGBA, 32'h80FF_4000);
        write_reg(CFG_FOG_START, 32'hFFFF_0000);
        write_reg(CFG_FOG_END, 32'h0001_0000);
        queue_frag(3, 3, -1, 255, 255, 255, 128);
        queue_frag(3, 3, -65536, 0, 0, 0, 0);
        queue_frag(3, 3, -30000, 255, 0, 0, 255);
        queue_frag(0, 255, -131072, 77, 77, 77, 200);
        queue_frag(9, 9, -20000, 100, 150, 200, 100);
        drain();

        // Random phases; each changes configuration and idling style.
        for (int p = 0; p < 14; p++) begin
            idle_mode = p % 4;
            program_phase(p);
            for (int i = 0; i < 124; i++) queue_random_frag();
            drain();
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run, including the store clear.
    initial begin
        #30ms;
        $display("tb failed");
        $finish;
    end

endmodule
